>>> rtl/deq_pkg.sv
// shared types, constants and handshake structs for the double-ended queue
package deq_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int VALUE_W        = 32;
    localparam int LENGTH_W       = 5;

    typedef enum logic [2:0] {
        CMD_PUSH_HEAD = 3'd0,
        CMD_PUSH_TAIL = 3'd1,
        CMD_POP_HEAD  = 3'd2,
        CMD_POP_TAIL  = 3'd3,
        CMD_PEEK_HEAD = 3'd4,
        CMD_PEEK_TAIL = 3'd5,
        CMD_CONTAINS  = 3'd6,
        CMD_CLEAR     = 3'd7
    } cmd_e;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_e;

    typedef struct packed {
        cmd_e                 cmd;
        logic [VALUE_W-1:0]   value;
    } req_t;

    typedef struct packed {
        status_e              status;
        logic [VALUE_W-1:0]   data;
        logic                 found;
        logic [LENGTH_W-1:0]  length;
    } rsp_t;

    // controller to datapath
    typedef struct packed {
        logic load_item;
        logic finish_exec;
        logic rd_peek;
        logic finish_peek;
        logic scan_start;
        logic scan_next;
        logic finish_scan;
    } deq_ctrl_t;

    // datapath to controller
    typedef struct packed {
        cmd_e cmd;
        logic empty;
        logic match;
        logic scan_last;
        logic out_free;
    } deq_stat_t;

endpackage

>>> rtl/deq_ram.sv
// generic single-write, single-read ram with registered read data
module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> rtl/deq_ctrl.sv
// sequencing state machine for the double-ended queue
module deq_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  deq_pkg::deq_stat_t  stat,
    output deq_pkg::deq_ctrl_t  ctrl
);
    import deq_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_PEEK,
        S_SCAN
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   is_peek;

    assign is_peek   = (stat.cmd == CMD_PEEK_HEAD) || (stat.cmd == CMD_PEEK_TAIL);
    assign req_stall = (state_reg != S_IDLE);

    always_comb
    begin
        ctrl       = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    ctrl.load_item = 1'b1;
                    state_next     = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (is_peek && !stat.empty)
                begin
                    ctrl.rd_peek = 1'b1;
                    state_next   = S_PEEK;
                end
                else if ((stat.cmd == CMD_CONTAINS) && !stat.empty)
                begin
                    ctrl.scan_start = 1'b1;
                    state_next      = S_SCAN;
                end
                else if (stat.out_free)
                begin
                    ctrl.finish_exec = 1'b1;
                    state_next       = S_IDLE;
                end
            end
            S_PEEK:
            begin
                if (stat.out_free)
                begin
                    ctrl.finish_peek = 1'b1;
                    state_next       = S_IDLE;
                end
            end
            S_SCAN:
            begin
                // read data holds while the result waits for the output register
                if (stat.match || stat.scan_last)
                begin
                    if (stat.out_free)
                    begin
                        ctrl.finish_scan = 1'b1;
                        state_next       = S_IDLE;
                    end
                end
                else
                begin
                    ctrl.scan_next = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> rtl/deq_dp.sv
// ring indices, element store, scan counter and output register
module deq_dp #(
    parameter int DEPTH      = deq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  deq_pkg::req_t       req,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output deq_pkg::rsp_t       rsp,
    input  deq_pkg::deq_ctrl_t  ctrl,
    output deq_pkg::deq_stat_t  stat
);
    import deq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] i);
        return (i == LAST_IDX) ? '0 : i + 1'b1;
    endfunction

    function automatic logic [AW-1:0] ring_prev(input logic [AW-1:0] i);
        return (i == '0) ? LAST_IDX : i - 1'b1;
    endfunction

    cmd_e               cmd_reg;
    logic [DATA_WIDTH-1:0] key_reg;
    logic [AW-1:0]      head_reg, head_next;
    logic [AW-1:0]      tail_reg, tail_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [AW-1:0]      scan_idx_reg, scan_idx_next;
    logic [CW-1:0]      scan_k_reg, scan_k_next;
    logic               rsp_valid_reg;
    rsp_t               rsp_reg, rsp_next;
    logic               load_rsp;

    logic               empty, full;
    logic               we, re;
    logic [AW-1:0]      waddr, raddr;
    logic [DATA_WIDTH-1:0] rdata;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == FULL_CNT);

    assign stat.cmd       = cmd_reg;
    assign stat.empty     = empty;
    assign stat.match     = (rdata == key_reg);
    assign stat.scan_last = (scan_k_reg == count_reg - 1'b1);
    assign stat.out_free  = !rsp_valid_reg || !rsp_stall;

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        head_next     = head_reg;
        tail_next     = tail_reg;
        count_next    = count_reg;
        scan_idx_next = scan_idx_reg;
        scan_k_next   = scan_k_reg;
        we            = 1'b0;
        waddr         = tail_reg;
        re            = 1'b0;
        raddr         = head_reg;
        rsp_next      = '0;
        load_rsp      = 1'b0;

        if (ctrl.finish_exec)
        begin
            load_rsp = 1'b1;
            case (cmd_reg)
                CMD_PUSH_HEAD:
                begin
                    if (full)
                    begin
                        rsp_next.status = ST_FULL;
                    end
                    else
                    begin
                        head_next  = ring_prev(head_reg);
                        we         = 1'b1;
                        waddr      = ring_prev(head_reg);
                        count_next = count_reg + 1'b1;
                    end
                end
                CMD_PUSH_TAIL:
                begin
                    if (full)
                    begin
                        rsp_next.status = ST_FULL;
                    end
                    else
                    begin
                        we         = 1'b1;
                        waddr      = tail_reg;
                        tail_next  = ring_next(tail_reg);
                        count_next = count_reg + 1'b1;
                    end
                end
                CMD_POP_HEAD:
                begin
                    if (empty)
                    begin
                        rsp_next.status = ST_EMPTY;
                    end
                    else
                    begin
                        head_next  = ring_next(head_reg);
                        count_next = count_reg - 1'b1;
                    end
                end
                CMD_POP_TAIL:
                begin
                    if (empty)
                    begin
                        rsp_next.status = ST_EMPTY;
                    end
                    else
                    begin
                        tail_next  = ring_prev(tail_reg);
                        count_next = count_reg - 1'b1;
                    end
                end
                CMD_PEEK_HEAD, CMD_PEEK_TAIL:
                begin
                    // only reached on an empty queue
                    rsp_next.status = ST_EMPTY;
                end
                CMD_CONTAINS:
                begin
                    rsp_next.status = ST_OK;
                end
                CMD_CLEAR:
                begin
                    head_next  = '0;
                    tail_next  = '0;
                    count_next = '0;
                end
                default:
                begin
                    rsp_next.status = ST_OK;
                end
            endcase
        end

        if (ctrl.rd_peek)
        begin
            re    = 1'b1;
            raddr = (cmd_reg == CMD_PEEK_TAIL) ? ring_prev(tail_reg) : head_reg;
        end

        if (ctrl.scan_start)
        begin
            re            = 1'b1;
            raddr         = head_reg;
            scan_idx_next = ring_next(head_reg);
            scan_k_next   = '0;
        end

        if (ctrl.scan_next)
        begin
            re            = 1'b1;
            raddr         = scan_idx_reg;
            scan_idx_next = ring_next(scan_idx_reg);
            scan_k_next   = scan_k_reg + 1'b1;
        end

        if (ctrl.finish_peek)
        begin
            load_rsp      = 1'b1;
            rsp_next.data = VALUE_W'(rdata);
        end

        if (ctrl.finish_scan)
        begin
            load_rsp       = 1'b1;
            rsp_next.found = (rdata == key_reg);
        end

        rsp_next.length = LENGTH_W'(count_next);
    end

    deq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (key_reg),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            if (load_rsp)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_item)
        begin
            cmd_reg <= req.cmd;
            key_reg <= DATA_WIDTH'(req.value);
        end
        scan_idx_reg <= scan_idx_next;
        scan_k_reg   <= scan_k_next;
        if (load_rsp)
        begin
            rsp_reg <= rsp_next;
        end
    end

endmodule

>>> rtl/double_ended_queue.sv
// top level of the bounded double-ended queue
//
//  channel | direction | handshake            | payload
//  req     | in        | req_valid, req_stall | cmd, value
//  rsp     | out       | rsp_valid, rsp_stall | status, data, found, length
//
// push, pop and clear: accept, then update and load result
// peek on a non-empty queue: accept, ram read, load result
// contains reads the stored elements from the head, one ram read per element, until the scan
// ends at a match or at the last stored element; on an empty queue it reads nothing
// reset clears indices, count and the result valid; the slot store is not cleared
// req_stall is high from the cycle after a transfer until its result is loaded;
// a stalled rsp holds the controller in its final state
module double_ended_queue #(
    parameter int DEPTH      = deq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  deq_pkg::req_t  req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output deq_pkg::rsp_t  rsp
);
    import deq_pkg::*;

    deq_ctrl_t ctrl;
    deq_stat_t stat;

    deq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .stat      (stat),
        .ctrl      (ctrl)
    );

    deq_dp #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .ctrl      (ctrl),
        .stat      (stat)
    );

endmodule

>>> rtl/deq_checker.sv
// port-level assertions for the double-ended queue, bound to the top level
module deq_checker #(
    parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    input  logic           req_stall,
    input  logic           rsp_valid,
    input  logic           rsp_stall,
    input  deq_pkg::rsp_t  rsp
);
    import deq_pkg::*;

    // a stalled result holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("stalled result changed");

    // one item at a time: a transfer closes the input right after it
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("input open right after a transfer");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.status != 2'd3)
        else $error("undefined status code");

    a_full_length: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == ST_FULL |-> rsp.length == LENGTH_W'(DEPTH))
        else $error("full status without a full queue");

    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == ST_EMPTY |-> rsp.length == '0 && rsp.data == '0
            && !rsp.found)
        else $error("empty status with stored elements or data");

endmodule

bind double_ended_queue deq_checker #(
    .DEPTH (DEPTH)
) u_deq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);

>>> dv/deque_checker.sv
`timescale 1ns / 1ps
// checker for the double-ended queue: watches both channels, predicts and compares results
module deque_checker #(
    parameter int DEPTH      = deq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    input  logic           req_stall,
    input  deq_pkg::req_t  req,
    input  logic           rsp_valid,
    input  logic           rsp_stall,
    input  deq_pkg::rsp_t  rsp,
    output int             fail_count,
    output int             pending
);
    import deq_pkg::*;

    localparam logic [VALUE_W-1:0] VAL_MASK =
        (DATA_WIDTH >= VALUE_W) ? {VALUE_W{1'b1}} : ((VALUE_W'(1) << DATA_WIDTH) - 1);
    localparam int PRINT_CAP = 200;

    logic [VALUE_W-1:0] slot_mem [DEPTH];
    int                 head_idx;
    int                 tail_idx;
    int                 used;
    rsp_t               expected_rsp [$];
    int                 errors = 0;

    assign fail_count = errors;

    task automatic report_mismatch(input string what, input logic [VALUE_W-1:0] got,
                                   input logic [VALUE_W-1:0] want);
        if (errors < PRINT_CAP)
            $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // advance the queue state by one command and work out its result
    task automatic apply_cmd(input req_t r, output rsp_t e);
        logic [VALUE_W-1:0] key;
        int                 idx;
        key = r.value & VAL_MASK;
        e = '0;
        e.status = ST_OK;
        case (r.cmd)
            CMD_PUSH_HEAD:
                if (used >= DEPTH)
                    e.status = ST_FULL;
                else
                begin
                    head_idx = (head_idx == 0) ? DEPTH - 1 : head_idx - 1;
                    slot_mem[head_idx] = key;
                    used++;
                end
            CMD_PUSH_TAIL:
                if (used >= DEPTH)
                    e.status = ST_FULL;
                else
                begin
                    slot_mem[tail_idx] = key;
                    tail_idx = (tail_idx + 1) % DEPTH;
                    used++;
                end
            CMD_POP_HEAD:
                if (used == 0)
                    e.status = ST_EMPTY;
                else
                begin
                    head_idx = (head_idx + 1) % DEPTH;
                    used--;
                end
            CMD_POP_TAIL:
                if (used == 0)
                    e.status = ST_EMPTY;
                else
                begin
                    tail_idx = (tail_idx == 0) ? DEPTH - 1 : tail_idx - 1;
                    used--;
                end
            CMD_PEEK_HEAD:
                if (used == 0)
                    e.status = ST_EMPTY;
                else
                    e.data = slot_mem[head_idx];
            CMD_PEEK_TAIL:
                if (used == 0)
                    e.status = ST_EMPTY;
                else
                    e.data = slot_mem[(tail_idx == 0) ? DEPTH - 1 : tail_idx - 1];
            CMD_CONTAINS:
            begin
                idx = head_idx;
                for (int k = 0; k < used; k++)
                begin
                    if (slot_mem[idx] == key)
                    begin
                        e.found = 1'b1;
                        break;
                    end
                    idx = (idx + 1) % DEPTH;
                end
            end
            default:
            begin
                head_idx = 0;
                tail_idx = 0;
                used = 0;
            end
        endcase
        e.length = LENGTH_W'(used);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        rsp_t fresh;
        if (!rst_n)
        begin
            head_idx = 0;
            tail_idx = 0;
            used = 0;
            expected_rsp.delete();
            pending <= 0;
        end
        else
        begin
            // results first: a result never belongs to a request of the same edge
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_rsp.size() == 0)
                    report_mismatch("result with nothing expected", rsp.data, '0);
                else
                begin
                    want = expected_rsp.pop_front();
                    if (rsp.status !== want.status)
                        report_mismatch("status", VALUE_W'(rsp.status),
                                        VALUE_W'(want.status));
                    if (rsp.data !== want.data)
                        report_mismatch("data", rsp.data, want.data);
                    if (rsp.found !== want.found)
                        report_mismatch("found", VALUE_W'(rsp.found), VALUE_W'(want.found));
                    if (rsp.length !== want.length)
                        report_mismatch("length", VALUE_W'(rsp.length),
                                        VALUE_W'(want.length));
                end
            end
            if (req_valid && !req_stall)
            begin
                apply_cmd(req, fresh);
                expected_rsp.push_back(fresh);
            end
            pending <= expected_rsp.size();
        end
    end

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps
// testbench top for the double-ended queue: clock, reset, stimulus and verdict
module testbench;
    import deq_pkg::*;

    localparam int DEPTH       = DEPTH_DEF;
    localparam int DATA_WIDTH  = DATA_WIDTH_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SEG_ITEMS   = 170;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    int send_pct = 0;
    int stall_pct = 0;
    int fail_count;
    int pending;
    int cycles = 0;

    // small pool so that pushes repeat and contains finds matches
    logic [VALUE_W-1:0] value_pool [8] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001,
                                          32'h8000_0000, 32'h5A5A_A5A5, 32'hA5A5_5A5A,
                                          32'h1234_5678, 32'h7FFF_FFFF};

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    double_ended_queue #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    deque_checker #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req        (req),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp        (rsp),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always @(posedge clk)
        rsp_stall <= ($urandom_range(99) < stall_pct);

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("testbench failed");
            $finish;
        end
    end

    function automatic logic [VALUE_W-1:0] pick_value();
        return ($urandom_range(2) == 0) ? VALUE_W'($urandom()) : value_pool[$urandom_range(7)];
    endfunction

    // one transfer on the request channel, with random idle cycles ahead of it
    task automatic send_req(input cmd_e c, input logic [VALUE_W-1:0] v);
        while ($urandom_range(99) < send_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= '{cmd: c, value: v};
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
    endtask

    initial
    begin
        int push_pct;
        int pop_pct;
        int burst;
        int r;
        int sent;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty queue corners
        send_req(CMD_CLEAR, 32'h0);
        send_req(CMD_POP_HEAD, 32'hFFFF_FFFF);
        send_req(CMD_POP_TAIL, 32'h0);
        send_req(CMD_PEEK_HEAD, 32'h0);
        send_req(CMD_PEEK_TAIL, 32'h0);
        send_req(CMD_CONTAINS, 32'h0);
        // push head wraps the head index below zero
        send_req(CMD_PUSH_HEAD, 32'hFFFF_FFFF);
        send_req(CMD_PUSH_TAIL, 32'h0);
        send_req(CMD_PEEK_HEAD, 32'h0);
        send_req(CMD_PEEK_TAIL, 32'h0);
        send_req(CMD_CONTAINS, 32'h0);
        // fill up, then push on a full queue at both ends
        for (int i = 0; i < DEPTH - 2; i++)
            send_req(CMD_PUSH_TAIL, VALUE_W'($urandom()));
        send_req(CMD_PUSH_HEAD, 32'h5A5A_A5A5);
        send_req(CMD_PUSH_TAIL, 32'hA5A5_5A5A);
        send_req(CMD_CLEAR, 32'hFFFF_FFFF);

        for (int seg = 0; seg < 8; seg++)
        begin
            case (seg % 4)
                0:
                begin
                    send_pct = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    send_pct = 45;
                    stall_pct = 0;
                end
                2:
                begin
                    send_pct = 0;
                    stall_pct = 45;
                end
                default:
                begin
                    send_pct = 16;
                    stall_pct = 16;
                end
            endcase
            sent = 0;
            while (sent < SEG_ITEMS)
            begin
                // bursts lean toward filling, draining or a balanced mix
                case ($urandom_range(2))
                    0:
                    begin
                        push_pct = 60;
                        pop_pct = 10;
                    end
                    1:
                    begin
                        push_pct = 10;
                        pop_pct = 60;
                    end
                    default:
                    begin
                        push_pct = 30;
                        pop_pct = 30;
                    end
                endcase
                burst = $urandom_range(24, 8);
                repeat (burst)
                begin
                    r = $urandom_range(99);
                    if (r < push_pct)
                        send_req($urandom_range(1) ? CMD_PUSH_TAIL : CMD_PUSH_HEAD, pick_value());
                    else if (r < push_pct + pop_pct)
                        send_req($urandom_range(1) ? CMD_POP_TAIL : CMD_POP_HEAD,
                                 VALUE_W'($urandom()));
                    else if (r < push_pct + pop_pct + 12)
                        send_req($urandom_range(1) ? CMD_PEEK_TAIL : CMD_PEEK_HEAD,
                                 VALUE_W'($urandom()));
                    else if (r < 99)
                        send_req(CMD_CONTAINS, pick_value());
                    else
                        send_req(CMD_CLEAR, VALUE_W'($urandom()));
                    sent++;
                end
            end
        end

        req_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
